/* rtl/chained_free_block_allocator_macros.svh */
// assertion macros used by the allocator rtl
`ifndef CHAINED_FREE_BLOCK_ALLOCATOR_MACROS_SVH
`define CHAINED_FREE_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CFBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CFBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cfba_pkg.sv */
// shared constants and types of the chained free block allocator
package cfba_pkg;

    localparam int CACHED_ENTRIES = 50;
    localparam int BLOCK_BITS     = 24;
    localparam int STACK_AW       = $clog2(CACHED_ENTRIES);
    localparam int COUNT_W        = 16;
    localparam int TOTAL_W        = 24;
    localparam int IDX_W          = 6;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_DATA_BLOCK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LIMIT       = 1'd1;

    typedef enum logic [1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_FREE   = 2'd1,
        MODE_HEADER = 2'd2,
        MODE_ENTRY  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_ALLOCATED     = 3'd0,
        KIND_NO_SPACE      = 3'd1,
        KIND_CHAIN_REQUEST = 3'd2,
        KIND_SPILL_HEADER  = 3'd3,
        KIND_SPILL_ENTRY   = 3'd4,
        KIND_FREED         = 3'd5,
        KIND_FREE_REJECTED = 3'd6
    } kind_t;

endpackage

/* rtl/cfba_req_if.sv */
// request channel: allocate, free and chain block items
interface cfba_req_if;
    logic                               valid;
    logic                               ready;
    cfba_pkg::mode_t                    mode;
    logic [cfba_pkg::BLOCK_BITS-1:0]    block_num;
    logic [cfba_pkg::COUNT_W-1:0]       chain_count;
    logic                               read_error;

    modport source (output valid, mode, block_num, chain_count, read_error, input ready);
    modport sink (input valid, mode, block_num, chain_count, read_error, output ready);
endinterface

/* rtl/cfba_rsp_if.sv */
// response channel: allocation, chain, spill and free results
interface cfba_rsp_if;
    logic                               valid;
    logic                               ready;
    cfba_pkg::kind_t                    kind;
    logic [cfba_pkg::BLOCK_BITS-1:0]    address;
    logic [cfba_pkg::BLOCK_BITS-1:0]    spill_value;
    logic [cfba_pkg::IDX_W-1:0]         entry_index;
    logic                               last;
    logic [cfba_pkg::TOTAL_W-1:0]       free_total;

    modport source (output valid, kind, address, spill_value, entry_index, last, free_total,
                    input ready);
    modport sink (input valid, kind, address, spill_value, entry_index, last, free_total,
                  output ready);
endinterface

/* rtl/chained_free_block_allocator.sv */
// top level of the chained free block allocator
// allocate: EXEC pops, ALLOC_CHK checks and skips out-of-range entries; an empty stack ends in EXEC
// free: EXEC, FREE_PUSH, reject in EXEC; spill: 1 header, 50 entries, 1 per cycle unless rsp stalls
// chain items pass IDLE and EXEC; one item at a time, as req.ready is high only in IDLE
// async active-low reset clears control and counters; stack ram contents are not cleared
`include "chained_free_block_allocator_macros.svh"

module chained_free_block_allocator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cfba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cfba_pkg::BLOCK_BITS-1:0]     cfg_wdata,
    cfba_req_if.sink                            req,
    cfba_rsp_if.source                          rsp
);

    localparam int BW = cfba_pkg::BLOCK_BITS;
    localparam int CW = cfba_pkg::COUNT_W;
    localparam int TW = cfba_pkg::TOTAL_W;
    localparam int AW = cfba_pkg::STACK_AW;
    localparam int FW = cfba_pkg::IDX_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ALLOC_CHK,
        ST_FREE_PUSH,
        ST_SPILL_HDR,
        ST_SPILL_ENT
    } state_t;

    function automatic logic out_of_range(input logic [BW-1:0] b, input logic [BW-1:0] lo,
                                          input logic [BW-1:0] hi);
        return (b < lo) || (b >= hi);
    endfunction

    state_t                 state_reg, state_next;
    logic [BW-1:0]          lowest_reg, lowest_next;
    logic [BW-1:0]          limit_reg, limit_next;
    cfba_pkg::mode_t        mode_reg, mode_next;
    logic [BW-1:0]          blk_reg, blk_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   err_reg, err_next;
    logic [CW-1:0]          stack_count_reg, stack_count_next;
    logic [TW-1:0]          total_free_reg, total_free_next;
    logic                   awaiting_chain_reg, awaiting_chain_next;
    logic                   header_taken_reg, header_taken_next;
    logic [BW-1:0]          pending_block_reg, pending_block_next;
    logic [FW-1:0]          fill_position_reg, fill_position_next;
    logic [AW-1:0]          spill_idx_reg, spill_idx_next;

    logic                   out_valid_reg, out_valid_next;
    cfba_pkg::kind_t        out_kind_reg, out_kind_next;
    logic [BW-1:0]          out_address_reg, out_address_next;
    logic [BW-1:0]          out_spill_reg, out_spill_next;
    logic [FW-1:0]          out_index_reg, out_index_next;
    logic                   out_last_reg, out_last_next;
    logic [TW-1:0]          out_total_reg, out_total_next;

    logic                   out_free;
    logic                   emit;
    logic                   do_nospace;
    cfba_pkg::kind_t        e_kind;
    logic [BW-1:0]          e_addr;
    logic [BW-1:0]          e_spill;
    logic [FW-1:0]          e_idx;
    logic                   e_last;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [BW-1:0]          ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [BW-1:0]          stack_rdata;
    logic [TW-1:0]          total_inc;
    logic [TW-1:0]          total_dec;

    cfba_ram #(
        .WIDTH (BW),
        .DEPTH (cfba_pkg::CACHED_ENTRIES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (stack_rdata)
    );

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign total_inc = (total_free_reg == '1) ? total_free_reg : total_free_reg + TW'(1);
    assign total_dec = (total_free_reg == '0) ? total_free_reg : total_free_reg - TW'(1);

    // spill reads follow the entry index, pops follow the stack count
    assign ram_raddr = (state_next == ST_SPILL_HDR || state_next == ST_SPILL_ENT)
                       ? spill_idx_next : stack_count_next[AW-1:0];

    always_comb
    begin
        state_next          = state_reg;
        lowest_next         = lowest_reg;
        limit_next          = limit_reg;
        mode_next           = mode_reg;
        blk_next            = blk_reg;
        cnt_next            = cnt_reg;
        err_next            = err_reg;
        stack_count_next    = stack_count_reg;
        total_free_next     = total_free_reg;
        awaiting_chain_next = awaiting_chain_reg;
        header_taken_next   = header_taken_reg;
        pending_block_next  = pending_block_reg;
        fill_position_next  = fill_position_reg;
        spill_idx_next      = spill_idx_reg;
        emit                = 1'b0;
        do_nospace          = 1'b0;
        e_kind              = cfba_pkg::KIND_ALLOCATED;
        e_addr              = '0;
        e_spill             = '0;
        e_idx               = '0;
        e_last              = 1'b1;
        ram_we              = 1'b0;
        ram_waddr           = '0;
        ram_wdata           = '0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                cfba_pkg::CFG_LOWEST_DATA_BLOCK: lowest_next = cfg_wdata;
                cfba_pkg::CFG_BLOCK_LIMIT:       limit_next  = cfg_wdata;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next  = req.mode;
                    blk_next   = req.block_num;
                    cnt_next   = req.chain_count;
                    err_next   = req.read_error;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                unique case (mode_reg)
                    cfba_pkg::MODE_ALLOC:
                    begin
                        if (awaiting_chain_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (stack_count_reg == '0)
                        begin
                            if (out_free)
                            begin
                                do_nospace = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            stack_count_next = stack_count_reg - CW'(1);
                            state_next       = ST_ALLOC_CHK;
                        end
                    end

                    cfba_pkg::MODE_FREE:
                    begin
                        if (awaiting_chain_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (out_of_range(blk_reg, lowest_reg, limit_reg))
                        begin
                            if (out_free)
                            begin
                                emit       = 1'b1;
                                e_kind     = cfba_pkg::KIND_FREE_REJECTED;
                                e_addr     = blk_reg;
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            total_free_next = total_inc;
                            if (stack_count_reg == '0)
                            begin
                                // empty stack gets a zero chain terminator first
                                ram_we           = 1'b1;
                                ram_waddr        = '0;
                                ram_wdata        = '0;
                                stack_count_next = CW'(1);
                                state_next       = ST_FREE_PUSH;
                            end
                            else if (stack_count_reg >= CW'(cfba_pkg::CACHED_ENTRIES))
                            begin
                                spill_idx_next = '0;
                                state_next     = ST_SPILL_HDR;
                            end
                            else
                            begin
                                state_next = ST_FREE_PUSH;
                            end
                        end
                    end

                    cfba_pkg::MODE_HEADER:
                    begin
                        if (!awaiting_chain_reg || header_taken_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (err_reg)
                        begin
                            if (out_free)
                            begin
                                do_nospace = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            stack_count_next   = cnt_reg;
                            fill_position_next = '0;
                            header_taken_next  = 1'b1;
                            state_next         = ST_IDLE;
                        end
                    end

                    cfba_pkg::MODE_ENTRY:
                    begin
                        if (!awaiting_chain_reg || !header_taken_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (fill_position_reg != FW'(cfba_pkg::CACHED_ENTRIES - 1))
                        begin
                            ram_we             = 1'b1;
                            ram_waddr          = fill_position_reg[AW-1:0];
                            ram_wdata          = blk_reg;
                            fill_position_next = fill_position_reg + FW'(1);
                            state_next         = ST_IDLE;
                        end
                        else if (out_free)
                        begin
                            // last entry of the chain block: check the count
                            ram_we              = 1'b1;
                            ram_waddr           = fill_position_reg[AW-1:0];
                            ram_wdata           = blk_reg;
                            fill_position_next  = fill_position_reg + FW'(1);
                            awaiting_chain_next = 1'b0;
                            header_taken_next   = 1'b0;
                            state_next          = ST_IDLE;
                            if (stack_count_reg == '0 ||
                                stack_count_reg > CW'(cfba_pkg::CACHED_ENTRIES))
                            begin
                                do_nospace = 1'b1;
                            end
                            else
                            begin
                                total_free_next = total_dec;
                                emit            = 1'b1;
                                e_kind          = cfba_pkg::KIND_ALLOCATED;
                                e_addr          = pending_block_reg;
                            end
                        end
                    end
                endcase
            end

            ST_ALLOC_CHK:
            begin
                priority if (stack_rdata == '0)
                begin
                    if (out_free)
                    begin
                        do_nospace = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (out_of_range(stack_rdata, lowest_reg, limit_reg))
                begin
                    if (stack_count_reg == '0)
                    begin
                        if (out_free)
                        begin
                            do_nospace = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        stack_count_next = stack_count_reg - CW'(1);
                    end
                end
                else if (stack_count_reg == '0)
                begin
                    if (out_free)
                    begin
                        awaiting_chain_next = 1'b1;
                        header_taken_next   = 1'b0;
                        pending_block_next  = stack_rdata;
                        fill_position_next  = '0;
                        emit                = 1'b1;
                        e_kind              = cfba_pkg::KIND_CHAIN_REQUEST;
                        e_addr              = stack_rdata;
                        state_next          = ST_IDLE;
                    end
                end
                else
                begin
                    if (out_free)
                    begin
                        total_free_next = total_dec;
                        emit            = 1'b1;
                        e_kind          = cfba_pkg::KIND_ALLOCATED;
                        e_addr          = stack_rdata;
                        state_next      = ST_IDLE;
                    end
                end
            end

            ST_FREE_PUSH:
            begin
                if (out_free)
                begin
                    ram_we           = 1'b1;
                    ram_waddr        = stack_count_reg[AW-1:0];
                    ram_wdata        = blk_reg;
                    stack_count_next = stack_count_reg + CW'(1);
                    emit             = 1'b1;
                    e_kind           = cfba_pkg::KIND_FREED;
                    e_addr           = blk_reg;
                    state_next       = ST_IDLE;
                end
            end

            ST_SPILL_HDR:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_kind     = cfba_pkg::KIND_SPILL_HEADER;
                    e_addr     = blk_reg;
                    e_spill    = BW'(stack_count_reg);
                    e_last     = 1'b0;
                    state_next = ST_SPILL_ENT;
                end
            end

            ST_SPILL_ENT:
            begin
                if (out_free)
                begin
                    emit    = 1'b1;
                    e_kind  = cfba_pkg::KIND_SPILL_ENTRY;
                    e_addr  = blk_reg;
                    e_spill = stack_rdata;
                    e_idx   = FW'(spill_idx_reg);
                    e_last  = (spill_idx_reg == AW'(cfba_pkg::CACHED_ENTRIES - 1));
                    if (e_last)
                    begin
                        // freed block becomes the only entry of the new stack
                        ram_we           = 1'b1;
                        ram_waddr        = '0;
                        ram_wdata        = blk_reg;
                        stack_count_next = CW'(1);
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        spill_idx_next = spill_idx_reg + AW'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_nospace)
        begin
            stack_count_next    = '0;
            total_free_next     = '0;
            awaiting_chain_next = 1'b0;
            header_taken_next   = 1'b0;
            emit                = 1'b1;
            e_kind              = cfba_pkg::KIND_NO_SPACE;
            e_addr              = '0;
            e_spill             = '0;
            e_idx               = '0;
            e_last              = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_kind_next    = out_kind_reg;
        out_address_next = out_address_reg;
        out_spill_next   = out_spill_reg;
        out_index_next   = out_index_reg;
        out_last_next    = out_last_reg;
        out_total_next   = out_total_reg;
        if (emit)
        begin
            out_valid_next   = 1'b1;
            out_kind_next    = e_kind;
            out_address_next = e_addr;
            out_spill_next   = e_spill;
            out_index_next   = e_idx;
            out_last_next    = e_last;
            out_total_next   = total_free_next;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            lowest_reg         <= BW'(2);
            limit_reg          <= '1;
            mode_reg           <= cfba_pkg::MODE_ALLOC;
            blk_reg            <= '0;
            cnt_reg            <= '0;
            err_reg            <= 1'b0;
            stack_count_reg    <= '0;
            total_free_reg     <= '0;
            awaiting_chain_reg <= 1'b0;
            header_taken_reg   <= 1'b0;
            pending_block_reg  <= '0;
            fill_position_reg  <= '0;
            spill_idx_reg      <= '0;
            out_valid_reg      <= 1'b0;
            out_kind_reg       <= cfba_pkg::KIND_ALLOCATED;
            out_address_reg    <= '0;
            out_spill_reg      <= '0;
            out_index_reg      <= '0;
            out_last_reg       <= 1'b0;
            out_total_reg      <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            lowest_reg         <= lowest_next;
            limit_reg          <= limit_next;
            mode_reg           <= mode_next;
            blk_reg            <= blk_next;
            cnt_reg            <= cnt_next;
            err_reg            <= err_next;
            stack_count_reg    <= stack_count_next;
            total_free_reg     <= total_free_next;
            awaiting_chain_reg <= awaiting_chain_next;
            header_taken_reg   <= header_taken_next;
            pending_block_reg  <= pending_block_next;
            fill_position_reg  <= fill_position_next;
            spill_idx_reg      <= spill_idx_next;
            out_valid_reg      <= out_valid_next;
            out_kind_reg       <= out_kind_next;
            out_address_reg    <= out_address_next;
            out_spill_reg      <= out_spill_next;
            out_index_reg      <= out_index_next;
            out_last_reg       <= out_last_next;
            out_total_reg      <= out_total_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.kind        = out_kind_reg;
    assign rsp.address     = out_address_reg;
    assign rsp.spill_value = out_spill_reg;
    assign rsp.entry_index = out_index_reg;
    assign rsp.last        = out_last_reg;
    assign rsp.free_total  = out_total_reg;

    `CFBA_ASSERT_NOW(a_count_bounded, !awaiting_chain_reg,
        stack_count_reg <= CW'(cfba_pkg::CACHED_ENTRIES),
        "stack count above capacity outside a chain read")
    `CFBA_ASSERT_NOW(a_header_needs_wait, header_taken_reg, awaiting_chain_reg,
        "chain header taken with no chain read pending")
    `CFBA_ASSERT_NOW(a_fill_bounded, awaiting_chain_reg,
        fill_position_reg < FW'(cfba_pkg::CACHED_ENTRIES),
        "chain fill position past the stack")
    `CFBA_ASSERT_NOW(a_nospace_clears,
        out_valid_reg && out_kind_reg == cfba_pkg::KIND_NO_SPACE,
        out_total_reg == '0 && out_address_reg == '0,
        "no_space result with nonzero total or address")
    `CFBA_ASSERT_NEXT(a_spill_follows, out_free && state_reg == ST_SPILL_HDR,
        out_valid_reg && out_kind_reg == cfba_pkg::KIND_SPILL_HEADER &&
        state_reg == ST_SPILL_ENT,
        "spill header not issued before entries")

endmodule

/* rtl/cfba_ram.sv */
// generic single-write, single-read ram with registered read data
module cfba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* bench/chained_free_block_allocator_tb.sv */
// self-checking testbench for the chained free block allocator: directed table plus random
module chained_free_block_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BW = cfba_pkg::BLOCK_BITS;
    localparam int CW = cfba_pkg::COUNT_W;
    localparam int TW = cfba_pkg::TOTAL_W;
    localparam int IW = cfba_pkg::IDX_W;
    localparam int NE = cfba_pkg::CACHED_ENTRIES;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PLAN_ROWS     = 27;
    localparam int PHASES        = 5;

    typedef struct {
        cfba_pkg::kind_t    kind;
        logic [BW-1:0]      address;
        logic [BW-1:0]      spill_value;
        logic [IW-1:0]      entry_index;
        logic               last;
        logic [TW-1:0]      free_total;
    } alloc_rsp_t;

    typedef struct {
        cfba_pkg::mode_t    mode;
        logic [BW-1:0]      blk;
        logic [CW-1:0]      cnt;
        logic               err;
        int                 reps;
        bit                 typed;
        cfba_pkg::kind_t    kind;
        logic [BW-1:0]      addr;
        logic [TW-1:0]      total;
    } plan_row_t;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               cfg_we;
    logic [cfba_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [BW-1:0]                      cfg_wdata;

    cfba_req_if req_ch ();
    cfba_rsp_if rsp_ch ();

    chained_free_block_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always #1 clk = ~clk;

    // shadow state of the allocator
    logic [BW-1:0]  blk_stack [NE];
    logic [CW-1:0]  stk_cnt;
    logic [TW-1:0]  free_tot;
    bit             waiting_chain;
    bit             hdr_seen;
    logic [BW-1:0]  chain_blk;
    logic [IW-1:0]  fill_pos;
    logic [BW-1:0]  lo_blk;
    logic [BW-1:0]  lim_blk;

    alloc_rsp_t due_responses [$];
    int         errors;
    bit         calm;

    plan_row_t plan [PLAN_ROWS] = '{
        '{cfba_pkg::MODE_ALLOC,  24'd0,      16'd0,    1'b0, 1,  1'b1,
          cfba_pkg::KIND_NO_SPACE,      24'd0,      24'd0},
        '{cfba_pkg::MODE_FREE,   24'd1,      16'd0,    1'b0, 1,  1'b1,
          cfba_pkg::KIND_FREE_REJECTED, 24'd1,      24'd0},
        '{cfba_pkg::MODE_FREE,   24'hFFFFFF, 16'd0,    1'b0, 1,  1'b1,
          cfba_pkg::KIND_FREE_REJECTED, 24'hFFFFFF, 24'd0},
        '{cfba_pkg::MODE_HEADER, 24'd0,      16'hFFFF, 1'b0, 1,  1'b0,
          cfba_pkg::KIND_ALLOCATED,     24'd0,      24'd0},
        '{cfba_pkg::MODE_ENTRY,  24'd77,     16'd0,    1'b0, 1,  1'b0,
          cfba_pkg::KIND_ALLOCATED,     24'd0,      24'd0},
        '{cfba_pkg::MODE_FREE,   24'hFFFFFE, 16'd0,    1'b0, 1,  1'b1,
          cfba_pkg::KIND_FREED,         24'hFFFFFE, 24'd1},
        '{cfba_pkg::MODE_FREE,   24'd2,      16'd0,    1'b0, 1,  1'b1,
          cfba_pkg::KIND_FREED,         24'd2,      24'd2},
        '{cfba_pkg::MODE_ALLOC,  24'd0,      16'd0,    1'b0, 1,  1'b1,
          cfba_pkg::KIND_ALLOCATED,     24'd2,      24'd1},
        '{cfba_pkg::MODE_ALLOC,  24'd0,      16'd0,    1'b0, 1,  1'b1,
          cfba_pkg::KIND_ALLOCATED,     24'hFFFFFE, 24'd0},
        '{cfba_pkg::MODE_ALLOC,  24'd0,      16'd0,    1'b0, 1,  1'b1,
          cfba_pkg::KIND_NO_SPACE,      24'd0,      24'd0},
        '{cfba_pkg::MODE_FREE,   24'd100,    16'd0,    1'b0, 49, 1'b0,
          cfba_pkg::KIND_ALLOCATED,     24'd0,      24'd0},
        '{cfba_pkg::MODE_FREE,   24'd5000,   16'd0,    1'b0, 1,  1'b0,
          cfba_pkg::KIND_ALLOCATED,     24'd0,      24'd0},
        '{cfba_pkg::MODE_FREE,   24'hFFFFFF, 16'd0,    1'b0, 1,  1'b1,
          cfba_pkg::KIND_FREE_REJECTED, 24'hFFFFFF, 24'd50},
        '{cfba_pkg::MODE_ALLOC,  24'd0,      16'd0,    1'b0, 1,  1'b1,
          cfba_pkg::KIND_CHAIN_REQUEST, 24'd5000,   24'd50},
        '{cfba_pkg::MODE_ALLOC,  24'd0,      16'd0,    1'b0, 1,  1'b0,
          cfba_pkg::KIND_ALLOCATED,     24'd0,      24'd0},
        '{cfba_pkg::MODE_FREE,   24'd300,    16'd0,    1'b0, 1,  1'b0,
          cfba_pkg::KIND_ALLOCATED,     24'd0,      24'd0},
        '{cfba_pkg::MODE_ENTRY,  24'd9,      16'd0,    1'b0, 1,  1'b0,
          cfba_pkg::KIND_ALLOCATED,     24'd0,      24'd0},
        '{cfba_pkg::MODE_HEADER, 24'd0,      16'd4,    1'b0, 1,  1'b0,
          cfba_pkg::KIND_ALLOCATED,     24'd0,      24'd0},
        '{cfba_pkg::MODE_HEADER, 24'd0,      16'd9,    1'b1, 1,  1'b0,
          cfba_pkg::KIND_ALLOCATED,     24'd0,      24'd0},
        '{cfba_pkg::MODE_ENTRY,  24'd150,    16'd0,    1'b0, 1,  1'b0,
          cfba_pkg::KIND_ALLOCATED,     24'd0,      24'd0},
        '{cfba_pkg::MODE_ENTRY,  24'd1,      16'd0,    1'b0, 1,  1'b0,
          cfba_pkg::KIND_ALLOCATED,     24'd0,      24'd0},
        '{cfba_pkg::MODE_ENTRY,  24'hFFFFFF, 16'd0,    1'b0, 1,  1'b0,
          cfba_pkg::KIND_ALLOCATED,     24'd0,      24'd0},
        '{cfba_pkg::MODE_ENTRY,  24'd200,    16'd0,    1'b0, 47, 1'b0,
          cfba_pkg::KIND_ALLOCATED,     24'd0,      24'd0},
        '{cfba_pkg::MODE_ALLOC,  24'd0,      16'd0,    1'b0, 1,  1'b1,
          cfba_pkg::KIND_ALLOCATED,     24'd200,    24'd48},
        '{cfba_pkg::MODE_ALLOC,  24'd0,      16'd0,    1'b0, 1,  1'b1,
          cfba_pkg::KIND_CHAIN_REQUEST, 24'd150,    24'd48},
        '{cfba_pkg::MODE_HEADER, 24'd0,      16'd3,    1'b1, 1,  1'b1,
          cfba_pkg::KIND_NO_SPACE,      24'd0,      24'd0},
        '{cfba_pkg::MODE_ALLOC,  24'd0,      16'd0,    1'b0, 1,  1'b1,
          cfba_pkg::KIND_NO_SPACE,      24'd0,      24'd0}
    };

    logic [BW-1:0] phase_lo [PHASES] =
        '{24'd2, 24'd0, 24'd1000, 24'hFFFFFF, 24'd5};
    logic [BW-1:0] phase_hi [PHASES] =
        '{24'hFFFFFF, 24'hFFFFFF, 24'd1100, 24'd0, 24'hFFFF00};
    int phase_items [PHASES] = '{90, 80, 80, 20, 40};

    function automatic void post(cfba_pkg::kind_t k, logic [BW-1:0] a,
                                 logic [BW-1:0] v, logic [IW-1:0] i, logic l);
        alloc_rsp_t r;
        r.kind        = k;
        r.address     = a;
        r.spill_value = v;
        r.entry_index = i;
        r.last        = l;
        r.free_total  = free_tot;
        due_responses.push_back(r);
    endfunction

    function automatic bit outside(logic [BW-1:0] b);
        return b < lo_blk || b >= lim_blk;
    endfunction

    function automatic void run_out();
        stk_cnt       = '0;
        free_tot      = '0;
        waiting_chain = 1'b0;
        hdr_seen      = 1'b0;
        post(cfba_pkg::KIND_NO_SPACE, '0, '0, '0, 1'b1);
    endfunction

    function automatic void take_block();
        logic [BW-1:0] b;
        bit found;
        bit empty;
        found = 1'b0;
        empty = 1'b0;
        b     = '0;
        while (!found && !empty)
        begin
            if (stk_cnt == 0)
            begin
                empty = 1'b1;
            end
            else
            begin
                stk_cnt = stk_cnt - 1'b1;
                b       = blk_stack[stk_cnt];
                if (b == 0)
                    empty = 1'b1;
                else if (!outside(b))
                    found = 1'b1;
            end
        end
        if (empty)
        begin
            run_out();
        end
        else if (stk_cnt == 0)
        begin
            waiting_chain = 1'b1;
            hdr_seen      = 1'b0;
            chain_blk     = b;
            fill_pos      = '0;
            post(cfba_pkg::KIND_CHAIN_REQUEST, b, '0, '0, 1'b1);
        end
        else
        begin
            if (free_tot != 0)
                free_tot = free_tot - 1'b1;
            post(cfba_pkg::KIND_ALLOCATED, b, '0, '0, 1'b1);
        end
    endfunction

    function automatic void give_block(logic [BW-1:0] b);
        bit spilled;
        spilled = 1'b0;
        if (outside(b))
        begin
            post(cfba_pkg::KIND_FREE_REJECTED, b, '0, '0, 1'b1);
        end
        else
        begin
            if (stk_cnt == 0)
            begin
                stk_cnt      = 16'd1;
                blk_stack[0] = '0;
            end
            if (free_tot != {TW{1'b1}})
                free_tot = free_tot + 1'b1;
            if (stk_cnt >= NE)
            begin
                post(cfba_pkg::KIND_SPILL_HEADER, b, BW'(stk_cnt), '0, 1'b0);
                for (int i = 0; i < NE; i++)
                    post(cfba_pkg::KIND_SPILL_ENTRY, b, blk_stack[i], IW'(i), i == NE - 1);
                stk_cnt = '0;
                spilled = 1'b1;
            end
            blk_stack[stk_cnt] = b;
            stk_cnt            = stk_cnt + 1'b1;
            if (!spilled)
                post(cfba_pkg::KIND_FREED, b, '0, '0, 1'b1);
        end
    endfunction

    // returns 0 when the allocator ignores the transaction
    function automatic bit apply_request(cfba_pkg::mode_t m, logic [BW-1:0] b,
                                         logic [CW-1:0] c, logic e);
        bit used;
        used = 1'b0;
        case (m)
            cfba_pkg::MODE_ALLOC:
                if (!waiting_chain)
                begin
                    take_block();
                    used = 1'b1;
                end
            cfba_pkg::MODE_FREE:
                if (!waiting_chain)
                begin
                    give_block(b);
                    used = 1'b1;
                end
            cfba_pkg::MODE_HEADER:
                if (waiting_chain && !hdr_seen)
                begin
                    used = 1'b1;
                    if (e)
                    begin
                        run_out();
                    end
                    else
                    begin
                        stk_cnt  = c;
                        fill_pos = '0;
                        hdr_seen = 1'b1;
                    end
                end
            default:
                if (waiting_chain && hdr_seen)
                begin
                    used                = 1'b1;
                    blk_stack[fill_pos] = b;
                    fill_pos            = fill_pos + 1'b1;
                    if (fill_pos >= NE)
                    begin
                        waiting_chain = 1'b0;
                        hdr_seen      = 1'b0;
                        if (stk_cnt == 0 || stk_cnt > NE)
                        begin
                            run_out();
                        end
                        else
                        begin
                            if (free_tot != 0)
                                free_tot = free_tot - 1'b1;
                            post(cfba_pkg::KIND_ALLOCATED, chain_blk, '0, '0, 1'b1);
                        end
                    end
                end
        endcase
        return used;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [BW-1:0] pick_block(int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct)
            return '0;
        if (r < 85 && lim_blk > lo_blk)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                return lo_blk;
            if (r == 1)
                return lim_blk - 1'b1;
            return lo_blk + BW'($urandom % 32'(lim_blk - lo_blk));
        end
        return BW'($urandom);
    endfunction

    function automatic void make_request(int free_pct, output cfba_pkg::mode_t m,
                                         output logic [BW-1:0] b,
                                         output logic [CW-1:0] c, output logic e);
        int r;
        int rc;
        r = $urandom_range(0, 99);
        b = BW'($urandom);
        c = CW'($urandom);
        e = 1'($urandom);
        m = cfba_pkg::MODE_ALLOC;
        if (waiting_chain && !hdr_seen)
        begin
            if (r < 85)
            begin
                m  = cfba_pkg::MODE_HEADER;
                e  = ($urandom_range(0, 9) == 0);
                rc = $urandom_range(0, 99);
                if (rc < 35)
                    c = CW'($urandom_range(45, NE));
                else if (rc < 80)
                    c = CW'($urandom_range(1, 44));
                else if (rc < 90)
                    c = '0;
                else if (rc < 95)
                    c = {CW{1'b1}};
                else
                    c = CW'($urandom_range(NE + 1, 65534));
            end
            else
            begin
                m = cfba_pkg::mode_t'($urandom_range(0, 3));
            end
        end
        else if (waiting_chain)
        begin
            if (r < 94)
            begin
                m = cfba_pkg::MODE_ENTRY;
                b = pick_block(2);
            end
            else
            begin
                m = cfba_pkg::mode_t'($urandom_range(0, 2));
            end
        end
        else if (r < 4)
        begin
            m = (r < 2) ? cfba_pkg::MODE_HEADER : cfba_pkg::MODE_ENTRY;
        end
        else if ($urandom_range(0, 99) < free_pct)
        begin
            m = cfba_pkg::MODE_FREE;
            b = pick_block(8);
        end
    endfunction

    task automatic send(input cfba_pkg::mode_t m, input logic [BW-1:0] b,
                        input logic [CW-1:0] c, input logic e,
                        output bit took, output int added);
        int gap;
        bit hold;
        int before_n;
        gap  = calm ? 0 : pick_gap();
        hold = !calm && ($urandom_range(0, 39) == 0);
        if (hold || gap > 0)
        begin
            req_ch.valid <= 1'b0;
            if (hold)
                while (due_responses.size() != 0)
                    @(negedge clk);
            repeat (gap > 0 ? gap : 1) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= m;
        req_ch.block_num   <= b;
        req_ch.chain_count <= c;
        req_ch.read_error  <= e;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        before_n = due_responses.size();
        took     = apply_request(m, b, c, e);
        added    = due_responses.size() - before_n;
        @(negedge clk);
    endtask

    task automatic settle(int extra);
        req_ch.valid <= 1'b0;
        while (due_responses.size() != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_range(logic [BW-1:0] lo, logic [BW-1:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= cfba_pkg::CFG_LOWEST_DATA_BLOCK;
        cfg_wdata <= lo;
        @(negedge clk);
        cfg_index <= cfba_pkg::CFG_BLOCK_LIMIT;
        cfg_wdata <= hi;
        @(negedge clk);
        cfg_we  <= 1'b0;
        lo_blk  = lo;
        lim_blk = hi;
    endtask

    function automatic void check_field(string name, logic [BW-1:0] want,
                                        logic [BW-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // response checker
    always @(posedge clk)
    begin
        alloc_rsp_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (due_responses.size() == 0)
            begin
                $error("kind: expected none, actual %0d", rsp_ch.kind);
                errors++;
            end
            else
            begin
                want = due_responses.pop_front();
                check_field("kind", BW'(want.kind), BW'(rsp_ch.kind));
                check_field("address", want.address, rsp_ch.address);
                check_field("spill_value", want.spill_value, rsp_ch.spill_value);
                check_field("entry_index", BW'(want.entry_index),
                            BW'(rsp_ch.entry_index));
                check_field("last", BW'(want.last), BW'(rsp_ch.last));
                check_field("free_total", want.free_total, rsp_ch.free_total);
            end
        end
    end

    // response back-pressure
    initial
    begin
        int hold_n;
        hold_n = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_n > 0)
            begin
                hold_n--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                hold_n = calm ? 0 : pick_gap();
                rsp_ch.ready <= (hold_n == 0);
                if (hold_n > 0)
                    hold_n--;
            end
        end
    end

    // watchdog
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("chained_free_block_allocator_tb: errors");
        $finish;
    end

    initial
    begin
        plan_row_t          row;
        alloc_rsp_t         want;
        cfba_pkg::mode_t    m;
        logic [BW-1:0]      b;
        logic [CW-1:0]      c;
        logic               e;
        bit                 took;
        int                 added;
        int                 done;
        int                 free_pct;
        int                 pct_opts [3];

        pct_opts      = '{15, 50, 85};
        errors        = 0;
        calm          = 1'b0;
        stk_cnt       = '0;
        free_tot      = '0;
        waiting_chain = 1'b0;
        hdr_seen      = 1'b0;
        chain_blk     = '0;
        fill_pos      = '0;
        lo_blk        = 24'd2;
        lim_blk       = 24'hFFFFFF;
        foreach (blk_stack[i])
            blk_stack[i] = '0;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= cfba_pkg::CFG_LOWEST_DATA_BLOCK;
        cfg_wdata          <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.mode        <= cfba_pkg::MODE_ALLOC;
        req_ch.block_num   <= '0;
        req_ch.chain_count <= '0;
        req_ch.read_error  <= 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_range(24'd2, 24'hFFFFFF);

        // directed table
        for (int k = 0; k < PLAN_ROWS; k++)
        begin
            row = plan[k];
            for (int j = 0; j < row.reps; j++)
            begin
                send(row.mode, row.blk + BW'(j), row.cnt, row.err, took, added);
                if (row.typed)
                begin
                    repeat (added) void'(due_responses.pop_back());
                    want.kind        = row.kind;
                    want.address     = row.addr;
                    want.spill_value = '0;
                    want.entry_index = '0;
                    want.last        = 1'b1;
                    want.free_total  = row.total;
                    due_responses.push_back(want);
                end
            end
        end

        // random phases, one range setting each
        for (int p = 0; p < PHASES; p++)
        begin
            settle(SETTLE_CYCLES);
            write_range(phase_lo[p], phase_hi[p]);
            done     = 0;
            free_pct = 50;
            while (done < phase_items[p])
            begin
                if (done % 40 == 0)
                    free_pct = pct_opts[$urandom_range(0, 2)];
                if (done % 60 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                make_request(free_pct, m, b, c, e);
                send(m, b, c, e, took, added);
                if (took)
                    done++;
            end
        end
        calm = 1'b0;

        settle(SETTLE_CYCLES);
        if (due_responses.size() != 0)
        begin
            $error("responses still outstanding: %0d", due_responses.size());
            errors++;
        end
        if (errors == 0)
            $display("chained_free_block_allocator_tb: clean");
        else
            $display("chained_free_block_allocator_tb: errors");
        $finish;
    end

endmodule
